// File: sv/nbmd_pkg.sv
// ----------------------------------------------------------------------------
// nbmd_pkg
// Shared constants, register codes, state encoding and status types for the
// nodata-aware block mean downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package nbmd_pkg;

  // Default sizing of the top level
  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_FACTOR  = 16;
  localparam int DEF_SAMPLE_BITS = 32;

  // Row limit; the height register can hold larger values, which are capped to it
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);

  // Configuration register widths and reset values
  localparam int FACTOR_BITS = 5;
  localparam int DIM_BITS    = 13;
  localparam int NODATA_BITS = 32;
  localparam int APB_DATA    = 32;
  localparam int APB_ADDR    = 4;

  localparam logic [FACTOR_BITS-1:0]        RST_FACTOR = 5'd2;
  localparam logic [DIM_BITS-1:0]           RST_WIDTH  = 13'd1024;
  localparam logic [DIM_BITS-1:0]           RST_HEIGHT = 13'd1024;
  localparam logic signed [NODATA_BITS-1:0] RST_NODATA = -32'sd2559744;

  // Register index (byte address divided by four)
  typedef enum logic [1:0] {
    REG_FACTOR = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NODATA = 2'd3
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DELIVER
  } state_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: sv/nbmd_channels.sv
// ----------------------------------------------------------------------------
// nbmd channels
// Valid/ready channels for input pixels and block mean results.
// ----------------------------------------------------------------------------
`default_nettype none

interface nbmd_pixel_if #(
  parameter int SAMPLE_BITS = nbmd_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface nbmd_mean_if #(
  parameter int SAMPLE_BITS = nbmd_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean_value;
  logic                          all_missing;
  logic                          row_end;
  logic                          frame_end;

  modport source (output valid, output mean_value, output all_missing,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input mean_value, input all_missing,
                  input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

// File: sv/nodata_aware_block_mean_downsample.sv
// A pixel that closes no block is folded into its column total by a read-modify-write
// (IDLE, UPDATE); a block-closing pixel goes on through the serial divider (DIVIDE) and
// DELIVER into the output register, and an all-nodata block skips the divider. No new
// request is taken until the sequencer is back in IDLE, and output stalls hold it in DELIVER.
// Reset, and any register write, clear the position counters and run a clearing pass
// over all MAX_WIDTH words of the column memory (4096 at default size), with no request taken.
// ----------------------------------------------------------------------------
// nodata_aware_block_mean_downsample
// Averages each n-by-n block of a row-major raster over the cells that differ
// from the nodata value and emits the mean at the block's bottom-right pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module nodata_aware_block_mean_downsample #(
  parameter int MAX_WIDTH  = nbmd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = nbmd_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  nbmd_pixel_if.sink                           in_ch,
  nbmd_mean_if.source                          out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nbmd_pkg::APB_ADDR-1:0]   paddr,
  input  wire logic [nbmd_pkg::APB_DATA-1:0]   pwdata,
  output      logic [nbmd_pkg::APB_DATA-1:0]   prdata,
  output      logic                            pready
);

  // Sample width is the package default, which the channel interfaces also use by default.
  localparam int SAMPLE_BITS = nbmd_pkg::DEF_SAMPLE_BITS;

  // Column address, in-block counter, sum and count widths all follow from
  // the sizing parameters: a block sums up to MAX_FACTOR^2 samples.
  localparam int CB         = $clog2(MAX_WIDTH);
  localparam int FB         = $clog2(MAX_FACTOR);
  localparam int SUM_BITS   = SAMPLE_BITS + 2 * FB;
  localparam int COUNT_BITS = 2 * FB + 1;
  localparam int WORD_BITS  = SUM_BITS + COUNT_BITS;
  localparam int RB         = nbmd_pkg::ROW_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        [nbmd_pkg::FACTOR_BITS-1:0] factor_r;
  logic        [nbmd_pkg::DIM_BITS-1:0]    width_r;
  logic        [nbmd_pkg::DIM_BITS-1:0]    height_r;
  logic signed [nbmd_pkg::NODATA_BITS-1:0] nodata_r;
  nbmd_pkg::reg_idx_t                      reg_idx;
  logic                                    cfg_we;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign reg_idx = nbmd_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= nbmd_pkg::RST_FACTOR;
      width_r  <= nbmd_pkg::RST_WIDTH;
      height_r <= nbmd_pkg::RST_HEIGHT;
      nodata_r <= nbmd_pkg::RST_NODATA;
    end else if (cfg_we) begin
      unique case (reg_idx)
        nbmd_pkg::REG_FACTOR: factor_r <= pwdata[nbmd_pkg::FACTOR_BITS-1:0];
        nbmd_pkg::REG_WIDTH:  width_r  <= pwdata[nbmd_pkg::DIM_BITS-1:0];
        nbmd_pkg::REG_HEIGHT: height_r <= pwdata[nbmd_pkg::DIM_BITS-1:0];
        nbmd_pkg::REG_NODATA: nodata_r <= pwdata[nbmd_pkg::NODATA_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      nbmd_pkg::REG_FACTOR: prdata = nbmd_pkg::APB_DATA'(factor_r);
      nbmd_pkg::REG_WIDTH:  prdata = nbmd_pkg::APB_DATA'(width_r);
      nbmd_pkg::REG_HEIGHT: prdata = nbmd_pkg::APB_DATA'(height_r);
      nbmd_pkg::REG_NODATA: prdata = nbmd_pkg::APB_DATA'(nodata_r);
      default:              prdata = '0;
    endcase
  end

  // Effective last indexes: factor 0 acts as 1 and is capped at MAX_FACTOR,
  // width 0 acts as 1 and is capped at MAX_WIDTH, height capped at the limit.
  logic [FB-1:0] last_in_blk;
  logic [CB-1:0] last_col;
  logic [RB-1:0] last_row;

  always_comb begin
    if (factor_r == '0) begin
      last_in_blk = '0;
    end else if (int'(factor_r) > MAX_FACTOR) begin
      last_in_blk = FB'(MAX_FACTOR - 1);
    end else begin
      last_in_blk = FB'(factor_r - 1'b1);
    end
    if (width_r == '0) begin
      last_col = '0;
    end else if (int'(width_r) > MAX_WIDTH) begin
      last_col = CB'(MAX_WIDTH - 1);
    end else begin
      last_col = CB'(width_r - 1'b1);
    end
    if (height_r == '0) begin
      last_row = '0;
    end else if (int'(height_r) > nbmd_pkg::HEIGHT_LIMIT) begin
      last_row = RB'(nbmd_pkg::HEIGHT_LIMIT - 1);
    end else begin
      last_row = RB'(height_r - 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Raster position counters
  // --------------------------------------------------------------------------
  logic [CB-1:0] in_col_r, in_col_nxt;
  logic [RB-1:0] in_row_r, in_row_nxt;
  logic [FB-1:0] band_row_r, band_row_nxt;
  logic [FB-1:0] blk_col_r, blk_col_nxt;
  logic [CB-1:0] out_col_r, out_col_nxt;
  logic          at_col_end, at_row_end, at_blk_col, at_band_row;
  logic          closes_blk;
  logic          accept;

  assign at_col_end  = in_col_r >= last_col;
  assign at_row_end  = in_row_r >= last_row;
  assign at_blk_col  = blk_col_r >= last_in_blk;
  assign at_band_row = band_row_r >= last_in_blk;
  assign closes_blk  = (at_blk_col | at_col_end) & (at_band_row | at_row_end);
  assign accept      = in_ch.valid & in_ch.ready;

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    band_row_nxt = band_row_r;
    blk_col_nxt  = blk_col_r;
    out_col_nxt  = out_col_r;
    if (at_col_end) begin
      // wrap to the next raster row, or to a new frame after the last one
      in_col_nxt  = '0;
      blk_col_nxt = '0;
      out_col_nxt = '0;
      if (at_row_end) begin
        in_row_nxt   = '0;
        band_row_nxt = '0;
      end else begin
        in_row_nxt   = in_row_r + 1'b1;
        band_row_nxt = at_band_row ? '0 : band_row_r + 1'b1;
      end
    end else begin
      in_col_nxt = in_col_r + 1'b1;
      if (at_blk_col) begin
        blk_col_nxt = '0;
        out_col_nxt = out_col_r + 1'b1;
      end else begin
        blk_col_nxt = blk_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      band_row_r <= '0;
      blk_col_r  <= '0;
      out_col_r  <= '0;
    end else if (accept) begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      band_row_r <= band_row_nxt;
      blk_col_r  <= blk_col_nxt;
      out_col_r  <= out_col_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Column accumulator memory: {sum, count} per output column
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] col_mem [MAX_WIDTH];
  logic [WORD_BITS-1:0] mem_rdata_r;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [CB-1:0]        mem_waddr;
  logic                 mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      mem_rdata_r <= col_mem[out_col_r];
    end
  end

  // --------------------------------------------------------------------------
  // Item held across the read-modify-write
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] pix_r;
  logic [CB-1:0]                 item_col_r;
  logic                          item_emit_r;
  logic                          item_row_end_r;
  logic                          item_frame_end_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r            <= in_ch.pixel_value;
      item_col_r       <= out_col_r;
      item_emit_r      <= closes_blk;
      item_row_end_r   <= at_col_end;
      item_frame_end_r <= at_col_end & at_row_end;
    end
  end

  // Fold the sample into the column total unless it carries the nodata mark.
  logic signed [SAMPLE_BITS-1:0] nodata_s;
  logic signed [SUM_BITS-1:0]    old_sum, new_sum;
  logic [COUNT_BITS-1:0]         old_cnt, new_cnt;
  logic                          pix_ok;

  assign nodata_s = SAMPLE_BITS'(nodata_r);
  assign pix_ok   = pix_r != nodata_s;
  assign old_sum  = mem_rdata_r[WORD_BITS-1:COUNT_BITS];
  assign old_cnt  = mem_rdata_r[COUNT_BITS-1:0];
  assign new_sum  = pix_ok ? old_sum + SUM_BITS'(pix_r) : old_sum;
  assign new_cnt  = old_cnt + COUNT_BITS'(pix_ok);

  // --------------------------------------------------------------------------
  // Divider
  // --------------------------------------------------------------------------
  logic                          div_start;
  logic signed [SAMPLE_BITS-1:0] div_quo;
  nbmd_pkg::div_stat_t           div_stat;

  nbmd_div #(
    .SUM_BITS    (SUM_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (new_cnt),
    .quotient (div_quo),
    .status   (div_stat)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  nbmd_pkg::state_t state_r, state_nxt;
  logic [CB-1:0]    clr_addr_r;
  logic             clr_last;
  logic             slot_free;
  logic             out_valid_r;

  assign clr_last  = clr_addr_r == CB'(MAX_WIDTH - 1);
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nbmd_pkg::ST_CLEAR:   if (clr_last) state_nxt = nbmd_pkg::ST_IDLE;
      nbmd_pkg::ST_IDLE:    if (accept) state_nxt = nbmd_pkg::ST_UPDATE;
      nbmd_pkg::ST_UPDATE: begin
        if (!item_emit_r) begin
          state_nxt = nbmd_pkg::ST_IDLE;
        end else if (new_cnt == '0) begin
          state_nxt = nbmd_pkg::ST_DELIVER;
        end else begin
          state_nxt = nbmd_pkg::ST_DIVIDE;
        end
      end
      nbmd_pkg::ST_DIVIDE:  if (div_stat.done) state_nxt = nbmd_pkg::ST_DELIVER;
      nbmd_pkg::ST_DELIVER: if (slot_free) state_nxt = nbmd_pkg::ST_IDLE;
      default:              state_nxt = nbmd_pkg::ST_CLEAR;
    endcase
    // any register write restarts the frame with a fresh clearing pass
    if (cfg_we) begin
      state_nxt = nbmd_pkg::ST_CLEAR;
    end
  end

  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = item_col_r;
    mem_wdata   = '0;
    div_start   = 1'b0;
    unique case (state_r)
      nbmd_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      nbmd_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      nbmd_pkg::ST_UPDATE: begin
        // a closed block leaves its column at zero for the next band
        mem_we    = 1'b1;
        mem_wdata = item_emit_r ? '0 : {new_sum, new_cnt};
        div_start = item_emit_r && (new_cnt != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= nbmd_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        clr_addr_r <= '0;
      end else if (state_r == nbmd_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pending result and output register
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] res_mean_r;
  logic                          res_missing_r;
  logic signed [SAMPLE_BITS-1:0] out_mean_r;
  logic                          out_missing_r;
  logic                          out_row_end_r;
  logic                          out_frame_end_r;

  always_ff @(posedge clk) begin
    if (state_r == nbmd_pkg::ST_UPDATE) begin
      res_mean_r    <= nodata_s;
      res_missing_r <= 1'b1;
    end else if (state_r == nbmd_pkg::ST_DIVIDE && div_stat.done) begin
      res_mean_r    <= div_quo;
      res_missing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == nbmd_pkg::ST_DELIVER && slot_free) begin
      out_mean_r      <= res_mean_r;
      out_missing_r   <= res_missing_r;
      out_row_end_r   <= item_row_end_r;
      out_frame_end_r <= item_frame_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == nbmd_pkg::ST_DELIVER && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mean_value  = out_mean_r;
  assign out_ch.all_missing = out_missing_r;
  assign out_ch.row_end     = out_row_end_r;
  assign out_ch.frame_end   = out_frame_end_r;

endmodule

`default_nettype wire

// File: sv/nbmd_div.sv
// ----------------------------------------------------------------------------
// nbmd_div
// Radix-2 restoring divider: signed block sum by unsigned nonzero count,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nbmd_div #(
  parameter int SUM_BITS    = 40,
  parameter int COUNT_BITS  = 9,
  parameter int SAMPLE_BITS = nbmd_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [SUM_BITS-1:0]    dividend,
  input  wire logic        [COUNT_BITS-1:0]  divisor,
  output      logic signed [SAMPLE_BITS-1:0] quotient,
  output      nbmd_pkg::div_stat_t           status
);

  localparam int STEP_BITS = $clog2(SUM_BITS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic [SUM_BITS-1:0]   quo_r, quo_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [COUNT_BITS-1:0] trial;
  logic [SUM_BITS-1:0]   quo_signed;

  // The remainder stays below the divisor, so its top bit is always free.
  assign trial = {rem_r[COUNT_BITS-2:0], quo_r[SUM_BITS-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[SUM_BITS-1];
      quo_nxt  = dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
    end else if (busy_r) begin
      if (trial >= dvs_r) begin
        rem_nxt = trial - dvs_r;
        quo_nxt = {quo_r[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SUM_BITS-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_BITS'(SUM_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    neg_r  <= neg_nxt;
  end

  assign quo_signed  = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient    = quo_signed[SAMPLE_BITS-1:0];
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

`default_nettype wire

// File: tb/sv/nodata_aware_block_mean_downsample_tb.sv
// ----------------------------------------------------------------------------
// nodata_aware_block_mean_downsample_tb
// Self-checking bench for the block mean downsampler. Pixel requests stream
// through the block under many block and raster settings. An in-bench model
// predicts every block mean with its nodata, row-end and frame-end flags, and
// a monitor compares each delivered mean against the oldest prediction.
// ----------------------------------------------------------------------------

module nodata_aware_block_mean_downsample_tb;
  import nbmd_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_N = DEF_MAX_FACTOR;
  // Covers the longest in-flight work, one divide, plus margin
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS  = 900;
  localparam int CLAMP_ITEMS   = 160;
  localparam longint LIMIT_TIME = 64'd80_000_000;
  localparam logic [31:0] MIN_SAMPLE = 32'h8000_0000;
  localparam logic [31:0] MAX_SAMPLE = 32'h7FFF_FFFF;

  typedef struct {
    logic signed [31:0] mean_value;
    logic               all_missing;
    logic               row_end;
    logic               frame_end;
  } block_mean_t;

  // Clock, reset and configuration port; all inputs known from time zero
  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [APB_ADDR-1:0] paddr   = '0;
  logic [APB_DATA-1:0] pwdata  = '0;
  logic [APB_DATA-1:0] prdata;
  logic                pready;

  nbmd_pixel_if pix_ch ();
  nbmd_mean_if  mean_ch ();

  nodata_aware_block_mean_downsample dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pix_ch),
    .out_ch  (mean_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // Shadow of the configuration registers
  logic [FACTOR_BITS-1:0] cfg_factor = RST_FACTOR;
  logic [DIM_BITS-1:0]    cfg_width  = RST_WIDTH;
  logic [DIM_BITS-1:0]    cfg_height = RST_HEIGHT;
  logic signed [31:0]     cfg_nodata = RST_NODATA;

  // Per output column accumulators and raster position of the model
  longint col_sum [MAX_W];
  int     col_cnt [MAX_W];
  int     in_col, in_row, band_row, blk_col, out_col;

  block_mean_t pending_means[$];

  bit idle_on = 1'b1;
  int rx_hold = 0;
  int n_pixels, n_random, n_means, n_missing, n_row_ends, n_frame_ends;
  int n_writes, n_errors;

  // Drop all partial blocks and return to the top-left pixel
  function automatic void clear_block_state();
    foreach (col_sum[i]) begin
      col_sum[i] = 0;
      col_cnt[i] = 0;
    end
    in_col   = 0;
    in_row   = 0;
    band_row = 0;
    blk_col  = 0;
    out_col  = 0;
  endfunction

  // Accumulate one accepted pixel; queue a block mean when it closes a block
  function automatic void predict_pixel(logic signed [31:0] pix);
    int          n, w, h, oc;
    bit          last_col, last_row;
    longint      quot;
    block_mean_t m;
    // Clamp the effective block and raster sizes
    n = cfg_factor;
    if (n == 0) n = 1;
    else if (n > MAX_N) n = MAX_N;
    w = cfg_width;
    if (w == 0) w = 1;
    else if (w > MAX_W) w = MAX_W;
    h = cfg_height;
    if (h == 0) h = 1;
    else if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    oc = (out_col >= MAX_W) ? MAX_W - 1 : out_col;

    // Skip nodata cells entirely
    if (pix != cfg_nodata) begin
      col_sum[oc] += longint'(pix);
      col_cnt[oc] += 1;
    end

    last_col = (in_col >= w - 1);
    last_row = (in_row >= h - 1);
    if ((blk_col >= n - 1 || last_col) && (band_row >= n - 1 || last_row)) begin
      m.all_missing = (col_cnt[oc] == 0);
      if (m.all_missing) begin
        m.mean_value = cfg_nodata;
      end else begin
        // Signed divide truncates toward zero
        quot = col_sum[oc] / longint'(col_cnt[oc]);
        m.mean_value = quot[31:0];
      end
      m.row_end   = last_col;
      m.frame_end = last_col && last_row;
      pending_means.push_back(m);
      col_sum[oc] = 0;
      col_cnt[oc] = 0;
    end

    // Advance the raster position, wrapping at row and frame ends
    if (last_col) begin
      in_col  = 0;
      blk_col = 0;
      out_col = 0;
      if (last_row) begin
        in_row   = 0;
        band_row = 0;
      end else begin
        in_row  += 1;
        band_row = (band_row >= n - 1) ? 0 : band_row + 1;
      end
    end else begin
      in_col += 1;
      if (blk_col >= n - 1) begin
        blk_col  = 0;
        out_col += 1;
      end else begin
        blk_col += 1;
      end
    end
  endfunction

  // Result side: hold ready low in random bursts while idling is enabled
  always @(negedge clk) begin : ready_drive
    logic rdy;
    if (rx_hold > 0) begin
      rx_hold -= 1;
      rdy = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_hold = $urandom_range(1, 7) - 1;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    mean_ch.ready <= rdy;
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    block_mean_t want;
    if (rst_n && mean_ch.valid && mean_ch.ready) begin
      n_means += 1;
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected mean %0d, nothing pending", $time, mean_ch.mean_value);
        n_errors += 1;
      end else begin
        want = pending_means.pop_front();
        if (mean_ch.mean_value !== want.mean_value) begin
          $display("%0t: mean_value expected %0d got %0d",
                   $time, want.mean_value, mean_ch.mean_value);
          n_errors += 1;
        end
        if (mean_ch.all_missing !== want.all_missing) begin
          $display("%0t: all_missing expected %b got %b",
                   $time, want.all_missing, mean_ch.all_missing);
          n_errors += 1;
        end
        if (mean_ch.row_end !== want.row_end) begin
          $display("%0t: row_end expected %b got %b", $time, want.row_end, mean_ch.row_end);
          n_errors += 1;
        end
        if (mean_ch.frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %b got %b",
                   $time, want.frame_end, mean_ch.frame_end);
          n_errors += 1;
        end
        n_missing    += want.all_missing;
        n_row_ends   += want.row_end;
        n_frame_ends += want.frame_end;
      end
    end
  end

  // Send one pixel request, with an optional idle burst ahead of it
  task automatic send_pixel(logic signed [31:0] pix);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      pix_ch.valid       <= 1'b0;
      pix_ch.pixel_value <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_value <= pix;
    do @(posedge clk); while (!pix_ch.ready);
    predict_pixel(pix);
    n_pixels += 1;
  endtask

  // Stop sending, wait for every pending mean, then let the block settle
  task automatic wait_idle(int extra);
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Read a register back and compare the bits it implements
  task automatic check_reg(reg_idx_t idx);
    logic [31:0] want, mask;
    case (idx)
      REG_FACTOR: begin want = 32'(cfg_factor); mask = 32'((64'd1 << FACTOR_BITS) - 1); end
      REG_WIDTH:  begin want = 32'(cfg_width);  mask = 32'((64'd1 << DIM_BITS) - 1); end
      REG_HEIGHT: begin want = 32'(cfg_height); mask = 32'((64'd1 << DIM_BITS) - 1); end
      REG_NODATA: begin want = cfg_nodata;      mask = '1; end
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (want & mask)) begin
      $display("%0t: register %s read expected %h got %h", $time, idx.name(), want, prdata);
      n_errors += 1;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register while the block is idle; any write restarts the frame
  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    wait_idle(SETTLE_CYCLES);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FACTOR: cfg_factor = data[FACTOR_BITS-1:0];
      REG_WIDTH:  cfg_width  = data[DIM_BITS-1:0];
      REG_HEIGHT: cfg_height = data[DIM_BITS-1:0];
      REG_NODATA: cfg_nodata = data;
    endcase
    clear_block_state();
    n_writes += 1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_reg(idx);
  endtask

  task automatic set_raster(int factor, int width, int height);
    write_reg(REG_FACTOR, factor);
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
  endtask

  // Random pixel: nodata at the given rate, else full range, near zero,
  // extremes, or one step off the nodata value
  function automatic logic [31:0] rand_pixel(int miss_pct);
    logic [31:0] r;
    if ($urandom_range(0, 99) < miss_pct) return cfg_nodata;
    r = cfg_nodata;
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 4000) - 2000;
      3: begin
        case ($urandom_range(0, 3))
          0:       return MAX_SAMPLE;
          1:       return MIN_SAMPLE;
          2:       return 32'd0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(0, 1) ? r + 32'd1 : r - 32'd1;
    endcase
  endfunction

  // Pick a register and a value; upper pwdata bits carry noise
  task automatic write_random_reg();
    reg_idx_t    idx;
    logic [31:0] data;
    int          pick;
    idx  = reg_idx_t'($urandom_range(0, 3));
    data = $urandom;
    pick = $urandom_range(0, 19);
    case (idx)
      REG_FACTOR: begin
        if (pick < 2)       data[FACTOR_BITS-1:0] = 0;
        else if (pick < 14) data[FACTOR_BITS-1:0] = $urandom_range(1, 5);
        else if (pick < 17) data[FACTOR_BITS-1:0] = $urandom_range(6, 16);
        else                data[FACTOR_BITS-1:0] = $urandom_range(17, 31);
      end
      REG_WIDTH, REG_HEIGHT: begin
        if (pick < 2)       data[DIM_BITS-1:0] = 0;
        else if (pick < 15) data[DIM_BITS-1:0] = $urandom_range(1, 24);
        else if (pick < 19) data[DIM_BITS-1:0] = $urandom_range(25, 48);
        else                data[DIM_BITS-1:0] = $urandom_range(4097, 8191);
      end
      REG_NODATA: begin
        if (pick < 5)       data = $urandom_range(0, 1) ? MIN_SAMPLE : MAX_SAMPLE;
        else if (pick < 10) data = $urandom_range(0, 2000) - 1000;
      end
    endcase
    write_reg(idx, data);
  endtask

  // Reset values read back before anything is written
  task automatic test_reset_values();
    check_reg(REG_FACTOR);
    check_reg(REG_WIDTH);
    check_reg(REG_HEIGHT);
    check_reg(REG_NODATA);
  endtask

  // Single-cell blocks carry the sample extremes straight through
  task automatic test_sample_extremes();
    logic [31:0] vals [6];
    vals = '{MAX_SAMPLE, MIN_SAMPLE, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0001};
    set_raster(1, 3, 2);
    write_reg(REG_NODATA, MIN_SAMPLE);
    foreach (vals[i]) send_pixel(vals[i]);
  endtask

  // Negative means truncate toward zero, not down
  task automatic test_mean_truncation();
    logic [31:0] vals [8];
    vals = '{32'hFFFF_FFFD, 32'd2, 32'hFFFF_FFF9, MIN_SAMPLE,
             MIN_SAMPLE, 32'd0, 32'hFFFF_FFFC, 32'd1};
    set_raster(2, 4, 2);
    foreach (vals[i]) send_pixel(vals[i]);
  endtask

  // 3x3 blocks on a 4x4 raster: cut right column, bottom row and corner,
  // one all-nodata block, then a second frame after the wrap
  task automatic test_partial_edges();
    set_raster(3, 4, 4);
    write_reg(REG_NODATA, 32'h0000_0100);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        send_pixel((c == 3 && r < 3) ? cfg_nodata : $urandom_range(0, 4000) - 2000);
      end
    end
    repeat (16) send_pixel(rand_pixel(30));
  endtask

  // Factor zero acts as one, all-ones factor acts as the maximum
  task automatic test_factor_clamp();
    set_raster(0, 2, 2);
    repeat (4) send_pixel(rand_pixel(20));
    set_raster(31, 18, 1);
    repeat (18) send_pixel(rand_pixel(20));
  endtask

  // Zero width and height act as one: every pixel closes the frame
  task automatic test_zero_dims();
    set_raster(2, 0, 0);
    send_pixel(cfg_nodata);
    repeat (3) send_pixel(rand_pixel(0));
  endtask

  // A register write mid-block discards the partial sums
  task automatic test_restart_on_write();
    set_raster(2, 2, 2);
    send_pixel(MAX_SAMPLE);
    send_pixel(MAX_SAMPLE);
    write_reg(REG_FACTOR, 2);
    repeat (4) send_pixel(rand_pixel(25));
  endtask

  // Oversized width and height: a stretch of one-row blocks along the first row,
  // then one-column blocks down the first column; run without idling
  task automatic test_size_clamp();
    idle_on = 1'b0;
    set_raster(16, 13'h1FFF, 1);
    repeat (CLAMP_ITEMS) send_pixel(rand_pixel(10));
    set_raster(16, 1, 13'h1FFF);
    repeat (CLAMP_ITEMS) send_pixel(rand_pixel(10));
    idle_on = 1'b1;
  endtask

  // Random phases: change one to three registers, then stream pixels
  task automatic test_random_phases();
    int miss_pct, len;
    while (n_random < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) write_random_reg();
      case ($urandom_range(0, 4))
        0:       miss_pct = 0;
        1:       miss_pct = 10;
        2:       miss_pct = 40;
        3:       miss_pct = 90;
        default: miss_pct = 100;
      endcase
      len = $urandom_range(30, 120);
      repeat (len) begin
        // Occasionally hold off until every pending mean has come out
        if ($urandom_range(0, 199) == 0) wait_idle(0);
        send_pixel(rand_pixel(miss_pct));
        n_random += 1;
      end
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    idle_on = 1'b0;
    set_raster(3, 10, 7);
    write_reg(REG_NODATA, 32'hFFFF_FF00);
    repeat (210) send_pixel(rand_pixel(15));
  endtask

  initial begin
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_value = '0;
    mean_ch.ready      = 1'b0;
    clear_block_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_sample_extremes();
    test_mean_truncation();
    test_partial_edges();
    test_factor_clamp();
    test_zero_dims();
    test_restart_on_write();
    test_size_clamp();
    test_random_phases();
    test_full_rate();

    // Drain, then watch for stray results
    wait_idle(SETTLE_CYCLES);
    $display("covered %0d pixels and %0d block means: %0d all nodata, %0d row ends,",
             n_pixels, n_means, n_missing, n_row_ends);
    $display("%0d frame ends, across %0d register writes with clamped sizes and restarts",
             n_frame_ends, n_writes);
    if (n_errors == 0) begin
      $display("[nodata_aware_block_mean_downsample] OK");
    end else begin
      $display("[nodata_aware_block_mean_downsample] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_TIME);
    $display("timeout with %0d means still pending", pending_means.size());
    $display("[nodata_aware_block_mean_downsample] ERROR");
    $finish;
  end

endmodule
